FILE: rtl/core/smf_pkg.sv
// ---------------------------------------------------------------------------
// smf_pkg: shared types and constants of the statistical mode finder
// Field widths, controller states and the command and status words that
// pass between the controller and the datapath.
// ---------------------------------------------------------------------------
package smf_pkg;

    localparam int VAL_W = 16;  // sample and mode value
    localparam int TOT_W = 6;   // mode count
    localparam int FRQ_W = 7;   // mode frequency

    typedef enum logic [3:0] {
        S_LOAD,
        S_PREP,
        S_P_CHK,
        S_P_RD0,
        S_P_FIRST,
        S_P_RUN,
        S_P_END,
        S_SC_RD,
        S_SC_CHK,
        S_EM_PREP,
        S_NOMODE,
        S_EM_RD,
        S_EM_CHK
    } t_state;

    typedef struct packed {
        logic ld;          // store the accepted input word
        logic lim_init;    // sort limit <= element count
        logic lim_dec;     // one sort pass done
        logic p_rd0;       // read element 0, start a pass
        logic p_first;     // take element 0 as the carried value
        logic p_run;       // compare and write back one element
        logic p_end;       // write the carried maximum at the limit
        logic sc_init;     // clear scan counters and statistics
        logic sc_rd;       // read element at scan index
        logic sc_chk;      // update longest run and mode count
        logic em_init;     // clear counters for the emit scan
        logic em_chk;      // advance the emit scan by one element
        logic out_nomode;  // load the no-mode word into the output register
        logic out_mode;    // load a mode word into the output register
        logic clr;         // clear count and overflow
    } t_cmd;

    typedef struct packed {
        logic lim_ge2;     // at least two elements left to sort
        logic idx_at_lim;  // this compare is the last of the pass
        logic i_last;      // scan index is on the last element
        logic total_zero;  // no value repeats
        logic hit;         // current element completes a longest run
        logic em_last;     // this mode is the last one
        logic out_free;    // output register can take a word
    } t_sts;

endpackage

FILE: rtl/core/smf_ctrl.sv
// ---------------------------------------------------------------------------
// smf_ctrl: sequencer of the statistical mode finder
// Steps through load, bubble sort passes, the run-length scan and the
// emit scan, issuing one command word per cycle to the datapath.
// ---------------------------------------------------------------------------
module smf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_final_sample,
    input  smf_pkg::t_sts i_sts,
    output smf_pkg::t_cmd o_cmd,
    output logic          o_in_stall
);

    smf_pkg::t_state r_state;
    smf_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= smf_pkg::S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            smf_pkg::S_LOAD: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.ld = 1'b1;
                    if (i_final_sample) begin
                        n_state = smf_pkg::S_PREP;
                    end
                end
            end
            smf_pkg::S_PREP: begin
                o_cmd.lim_init = 1'b1;
                n_state        = smf_pkg::S_P_CHK;
            end
            smf_pkg::S_P_CHK: begin
                if (i_sts.lim_ge2) begin
                    n_state = smf_pkg::S_P_RD0;
                end else begin
                    o_cmd.sc_init = 1'b1;
                    n_state       = smf_pkg::S_SC_RD;
                end
            end
            smf_pkg::S_P_RD0: begin
                o_cmd.p_rd0 = 1'b1;
                n_state     = smf_pkg::S_P_FIRST;
            end
            smf_pkg::S_P_FIRST: begin
                o_cmd.p_first = 1'b1;
                n_state       = smf_pkg::S_P_RUN;
            end
            smf_pkg::S_P_RUN: begin
                o_cmd.p_run = 1'b1;
                if (i_sts.idx_at_lim) begin
                    n_state = smf_pkg::S_P_END;
                end
            end
            smf_pkg::S_P_END: begin
                o_cmd.p_end   = 1'b1;
                o_cmd.lim_dec = 1'b1;
                n_state       = smf_pkg::S_P_CHK;
            end
            smf_pkg::S_SC_RD: begin
                o_cmd.sc_rd = 1'b1;
                n_state     = smf_pkg::S_SC_CHK;
            end
            smf_pkg::S_SC_CHK: begin
                o_cmd.sc_chk = 1'b1;
                if (i_sts.i_last) begin
                    n_state = smf_pkg::S_EM_PREP;
                end else begin
                    n_state = smf_pkg::S_SC_RD;
                end
            end
            smf_pkg::S_EM_PREP: begin
                if (i_sts.total_zero) begin
                    n_state = smf_pkg::S_NOMODE;
                end else begin
                    o_cmd.em_init = 1'b1;
                    n_state       = smf_pkg::S_EM_RD;
                end
            end
            smf_pkg::S_NOMODE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_nomode = 1'b1;
                    o_cmd.clr        = 1'b1;
                    n_state          = smf_pkg::S_LOAD;
                end
            end
            smf_pkg::S_EM_RD: begin
                o_cmd.sc_rd = 1'b1;
                n_state     = smf_pkg::S_EM_CHK;
            end
            smf_pkg::S_EM_CHK: begin
                // a mode word waits here until the output register frees up
                if (!i_sts.hit || i_sts.out_free) begin
                    o_cmd.em_chk = 1'b1;
                    if (i_sts.hit) begin
                        o_cmd.out_mode = 1'b1;
                    end
                    if ((i_sts.hit && i_sts.em_last) || i_sts.i_last) begin
                        o_cmd.clr = 1'b1;
                        n_state   = smf_pkg::S_LOAD;
                    end else begin
                        n_state = smf_pkg::S_EM_RD;
                    end
                end
            end
            default: begin
                n_state = smf_pkg::S_LOAD;
            end
        endcase
    end

endmodule

FILE: rtl/core/smf_dp.sv
// ---------------------------------------------------------------------------
// smf_dp: datapath of the statistical mode finder
// Sample memory with one write and one registered read port, the bubble
// sort compare/swap unit, run-length counters and the output register.
// ---------------------------------------------------------------------------
module smf_dp #(
    parameter int DEPTH = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  smf_pkg::t_cmd                     i_cmd,
    output smf_pkg::t_sts                     o_sts,
    input  logic signed [smf_pkg::VAL_W-1:0]  i_sample_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [smf_pkg::VAL_W-1:0]  o_mode_value,
    output logic        [smf_pkg::TOT_W-1:0]  o_mode_total,
    output logic        [smf_pkg::FRQ_W-1:0]  o_mode_frequency,
    output logic                              o_overflowed,
    output logic                              o_final_result
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic signed [smf_pkg::VAL_W-1:0] r_mem [DEPTH];
    logic signed [smf_pkg::VAL_W-1:0] r_rdata;
    logic signed [smf_pkg::VAL_W-1:0] r_cur;
    logic signed [smf_pkg::VAL_W-1:0] r_prev;

    logic [CW-1:0] r_count;
    logic          r_ovf;
    logic [CW-1:0] r_lim;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_i;
    logic [CW-1:0] r_run;
    logic [CW-1:0] r_best;
    logic [CW-1:0] r_total;
    logic [CW-1:0] r_k;

    logic                             mem_we;
    logic [AW-1:0]                    mem_waddr;
    logic signed [smf_pkg::VAL_W-1:0] mem_wdata;
    logic                             mem_re;
    logic [AW-1:0]                    mem_raddr;

    logic [CW-1:0] idx_m2;
    logic [CW-1:0] lim_m1;
    logic [CW-1:0] run_inc;
    logic [CW-1:0] k_inc;
    logic [CW-1:0] count_m1;
    logic [CW-1:0] best_p1;
    logic          cur_gt;
    logic          eq;
    logic          out_free;

    logic                             r_out_valid;
    logic signed [smf_pkg::VAL_W-1:0] r_out_value;
    logic [CW-1:0]                    r_out_total;
    logic [CW-1:0]                    r_out_freq;
    logic                             r_out_ovf;
    logic                             r_out_final;

    assign idx_m2   = r_idx - CW'(2);
    assign lim_m1   = r_lim - CW'(1);
    assign run_inc  = r_run + CW'(1);
    assign k_inc    = r_k + CW'(1);
    assign count_m1 = r_count - CW'(1);
    assign best_p1  = r_best + CW'(1);
    assign cur_gt   = r_cur > r_rdata;
    assign eq       = r_rdata == r_prev;
    assign out_free = !r_out_valid || !i_out_stall;

    assign o_sts.lim_ge2    = r_lim >= CW'(2);
    assign o_sts.idx_at_lim = r_idx == r_lim;
    assign o_sts.i_last     = r_i == count_m1;
    assign o_sts.total_zero = r_total == '0;
    assign o_sts.hit        = (r_i != '0) && eq && (run_inc == r_best);
    assign o_sts.em_last    = k_inc == r_total;
    assign o_sts.out_free   = out_free;

    // memory port selection
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_count[AW-1:0];
        mem_wdata = i_sample_value;
        mem_re    = 1'b0;
        mem_raddr = r_i[AW-1:0];
        if (i_cmd.ld) begin
            mem_we = r_count < CW'(DEPTH);
        end
        if (i_cmd.p_run) begin
            mem_we    = 1'b1;
            mem_waddr = idx_m2[AW-1:0];
            mem_wdata = cur_gt ? r_rdata : r_cur;
        end
        if (i_cmd.p_end) begin
            mem_we    = 1'b1;
            mem_waddr = lim_m1[AW-1:0];
            mem_wdata = r_cur;
        end
        if (i_cmd.p_rd0) begin
            mem_re    = 1'b1;
            mem_raddr = '0;
        end
        if (i_cmd.p_first || i_cmd.p_run) begin
            mem_re    = 1'b1;
            mem_raddr = r_idx[AW-1:0];
        end
        if (i_cmd.sc_rd) begin
            mem_re    = 1'b1;
            mem_raddr = r_i[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    // element count and overflow
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.clr) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.ld) begin
            if (r_count < CW'(DEPTH)) begin
                r_count <= r_count + CW'(1);
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

    // sort passes: carry the running maximum upward, write back the smaller
    always_ff @(posedge i_clk) begin
        if (i_cmd.lim_init) begin
            r_lim <= r_count;
        end else if (i_cmd.lim_dec) begin
            r_lim <= lim_m1;
        end
        if (i_cmd.p_rd0) begin
            r_idx <= CW'(1);
        end else if (i_cmd.p_first || i_cmd.p_run) begin
            r_idx <= r_idx + CW'(1);
        end
        if (i_cmd.p_first) begin
            r_cur <= r_rdata;
        end else if (i_cmd.p_run && !cur_gt) begin
            r_cur <= r_rdata;
        end
    end

    // run-length scan and emit scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.sc_init) begin
            r_i     <= '0;
            r_run   <= '0;
            r_best  <= '0;
            r_total <= '0;
        end else if (i_cmd.em_init) begin
            r_i   <= '0;
            r_run <= '0;
            r_k   <= '0;
        end else if (i_cmd.sc_chk || i_cmd.em_chk) begin
            r_i    <= r_i + CW'(1);
            r_prev <= r_rdata;
            if (r_i != '0) begin
                r_run <= eq ? run_inc : '0;
            end
            if (i_cmd.sc_chk && (r_i != '0) && eq) begin
                if (run_inc > r_best) begin
                    r_best  <= run_inc;
                    r_total <= CW'(1);
                end else if (run_inc == r_best) begin
                    r_total <= r_total + CW'(1);
                end
            end
            if (i_cmd.out_mode) begin
                r_k <= k_inc;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_nomode || i_cmd.out_mode) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_nomode) begin
            r_out_value <= '0;
            r_out_total <= '0;
            r_out_freq  <= CW'(1);
            r_out_ovf   <= r_ovf;
            r_out_final <= 1'b1;
        end else if (i_cmd.out_mode) begin
            r_out_value <= r_rdata;
            r_out_total <= r_total;
            r_out_freq  <= best_p1;
            r_out_ovf   <= r_ovf;
            r_out_final <= k_inc == r_total;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_mode_value     = r_out_value;
    assign o_mode_total     = smf_pkg::TOT_W'(r_out_total);
    assign o_mode_frequency = smf_pkg::FRQ_W'(r_out_freq);
    assign o_overflowed     = r_out_ovf;
    assign o_final_result   = r_out_final;

endmodule

FILE: rtl/core/statistical_mode_finder.sv
// ---------------------------------------------------------------------------
// statistical_mode_finder: multimode of a set of signed 16-bit values
// Loads a set, sorts it, finds the longest run and emits every mode.
// ---------------------------------------------------------------------------
// Loading takes one word per cycle until the word marked final; up to DEPTH
// words are kept, later ones are dropped and reported as overflowed. After
// the final word the input stalls while the set is processed in one memory
// with one write and one registered read port: bubble sort passes with a
// limit L from n down to 2, then a scan for the longest run and the mode
// count, then an emit scan that writes one mode word per hit and waits
// while the output stalls. Modes come out in ascending order; a set with
// no repeated value gives one word with mode total 0 and frequency 1.
// Input opens again as soon as the last result sits in the output register.
// ---------------------------------------------------------------------------
module statistical_mode_finder #(
    parameter int DEPTH = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [smf_pkg::VAL_W-1:0]  i_sample_value,
    input  logic                              i_final_sample,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [smf_pkg::VAL_W-1:0]  o_mode_value,
    output logic        [smf_pkg::TOT_W-1:0]  o_mode_total,
    output logic        [smf_pkg::FRQ_W-1:0]  o_mode_frequency,
    output logic                              o_overflowed,
    output logic                              o_final_result
);

    smf_pkg::t_cmd cmd;
    smf_pkg::t_sts sts;

    smf_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_final_sample (i_final_sample),
        .i_sts          (sts),
        .o_cmd          (cmd),
        .o_in_stall     (o_in_stall)
    );

    smf_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_sample_value   (i_sample_value),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_mode_value     (o_mode_value),
        .o_mode_total     (o_mode_total),
        .o_mode_frequency (o_mode_frequency),
        .o_overflowed     (o_overflowed),
        .o_final_result   (o_final_result)
    );

endmodule
